@@ rtl/core/gbw_pkg.sv @@
// Shared types and constants for the glyph box line and word grouper.
`default_nettype none

package gbw_pkg;

  typedef logic [15:0] f16_t;

  typedef enum logic {
    REC_LINE = 1'b0,
    REC_WORD = 1'b1
  } rec_kind_t;

  // which records of a bundle are present, in emission order
  typedef struct packed {
    logic line0;
    logic word;
    logic line1;
  } rec_mask_t;

  // all records caused by one input item, already in output format
  typedef struct packed {
    rec_mask_t has;
    f16_t      l0_left;
    f16_t      l0_right;
    f16_t      l0_top;
    f16_t      l0_bottom;
    f16_t      l0_first;
    f16_t      l0_count;
    f16_t      w_left;
    f16_t      w_right;
    f16_t      ln_left;
    f16_t      ln_right;
    f16_t      ln_top;
    f16_t      ln_bottom;
    f16_t      ln_first;
    f16_t      ln_count;
  } bundle_t;

  localparam int QUEUE_DEPTH    = 4;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

endpackage

`default_nettype wire

@@ rtl/core/gbw_front.sv @@
// Front end: accepts glyph boxes, tracks the open line and word, builds record bundles.
`default_nettype none

module gbw_front
  import gbw_pkg::*;
#(
  parameter int COORD_BITS = 16,
  parameter int INDEX_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_box_left,
  input  logic signed [15:0] in_box_right,
  input  logic signed [15:0] in_box_top,
  input  logic signed [15:0] in_box_bottom,
  input  logic               in_is_space,
  input  logic               in_first_of_page,
  input  logic               in_last_of_page,
  output logic               push_valid,
  input  logic               push_ready,
  output bundle_t            push_data
);

  localparam int CB = COORD_BITS;
  localparam int IB = INDEX_BITS;
  localparam logic [IB-1:0] IDX_MAX = {IB{1'b1}};

  typedef logic signed [CB-1:0] coord_t;
  typedef logic [IB-1:0]        index_t;

  coord_t line_left_r, line_right_r, line_top_r, line_bottom_r;
  coord_t line_left_nxt, line_right_nxt, line_top_nxt, line_bottom_nxt;
  index_t line_start_r, line_start_nxt;
  index_t char_pos_r, char_pos_nxt;
  logic   word_open_r, word_open_nxt;
  coord_t word_start_r, word_start_nxt;
  coord_t prev_right_r, prev_right_nxt;
  logic   page_open_r, page_open_nxt;

  coord_t bl, br, bt, bb;
  logic   accept, restart, overlap;
  index_t idx;
  coord_t nl_left, nl_right, nl_top, nl_bottom;
  index_t nl_start, nl_pos;
  coord_t nw_start;
  logic   emit_line0, emit_word_sp, emit_word_last;

  function automatic coord_t from16(input logic [15:0] v);
    logic [CB+15:0] x;
    x = {{CB{1'b0}}, v};
    return coord_t'(x[CB-1:0]);
  endfunction

  function automatic f16_t to16c(input coord_t c);
    logic signed [CB+15:0] x;
    x = (CB+16)'(c);
    return x[15:0];
  endfunction

  function automatic f16_t to16i(input index_t v);
    logic [IB+15:0] x;
    x = {16'b0, v};
    return x[15:0];
  endfunction

  // span plus one, saturating at the index maximum
  function automatic index_t line_count(input index_t start, input index_t pos);
    logic [IB:0] span;
    logic [IB:0] cnt;
    span = {1'b0, pos} - {1'b0, start};
    cnt  = (pos >= start) ? span + (IB+1)'(1) : (IB+1)'(1);
    return (cnt > {1'b0, IDX_MAX}) ? IDX_MAX : cnt[IB-1:0];
  endfunction

  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    bl = from16(in_box_left);
    br = from16(in_box_right);
    bt = from16(in_box_top);
    bb = from16(in_box_bottom);

    restart = in_first_of_page || !page_open_r;
    idx     = (char_pos_r == IDX_MAX) ? char_pos_r : char_pos_r + index_t'(1);
    overlap = (bt <= line_bottom_r) && (bb >= line_top_r);

    if (restart || !overlap) begin
      nl_left   = bl;
      nl_right  = br;
      nl_top    = bt;
      nl_bottom = bb;
    end else begin
      nl_left   = (bl < line_left_r)   ? bl : line_left_r;
      nl_right  = (br > line_right_r)  ? br : line_right_r;
      nl_top    = (bt < line_top_r)    ? bt : line_top_r;
      nl_bottom = (bb > line_bottom_r) ? bb : line_bottom_r;
    end

    if (restart) begin
      nl_start = '0;
      nl_pos   = '0;
    end else begin
      nl_start = overlap ? line_start_r : idx;
      nl_pos   = idx;
    end

    // a non-space box opens a word only when none is open
    nw_start = (restart || (!in_is_space && !word_open_r)) ? bl : word_start_r;

    emit_line0     = !restart && !overlap;
    emit_word_sp   = !restart && in_is_space && word_open_r;
    emit_word_last = in_last_of_page && !in_is_space;
  end

  always_comb begin
    push_data.has.line0 = emit_line0;
    push_data.has.word  = emit_word_sp || emit_word_last;
    push_data.has.line1 = in_last_of_page;
    push_data.l0_left   = to16c(line_left_r);
    push_data.l0_right  = to16c(line_right_r);
    push_data.l0_top    = to16c(line_top_r);
    push_data.l0_bottom = to16c(line_bottom_r);
    push_data.l0_first  = to16i(line_start_r);
    push_data.l0_count  = to16i(line_count(line_start_r, char_pos_r));
    push_data.w_left    = to16c(nw_start);
    push_data.w_right   = emit_word_sp ? to16c(prev_right_r) : to16c(br);
    push_data.ln_left   = to16c(nl_left);
    push_data.ln_right  = to16c(nl_right);
    push_data.ln_top    = to16c(nl_top);
    push_data.ln_bottom = to16c(nl_bottom);
    push_data.ln_first  = to16i(nl_start);
    push_data.ln_count  = to16i(line_count(nl_start, nl_pos));
    push_valid = accept && (emit_line0 || emit_word_sp || in_last_of_page);
  end

  always_comb begin
    line_left_nxt   = line_left_r;
    line_right_nxt  = line_right_r;
    line_top_nxt    = line_top_r;
    line_bottom_nxt = line_bottom_r;
    line_start_nxt  = line_start_r;
    char_pos_nxt    = char_pos_r;
    word_open_nxt   = word_open_r;
    word_start_nxt  = word_start_r;
    prev_right_nxt  = prev_right_r;
    page_open_nxt   = page_open_r;
    if (accept) begin
      if (in_last_of_page) begin
        line_left_nxt   = '0;
        line_right_nxt  = '0;
        line_top_nxt    = '0;
        line_bottom_nxt = '0;
        line_start_nxt  = '0;
        char_pos_nxt    = '0;
        word_open_nxt   = 1'b0;
        word_start_nxt  = '0;
        prev_right_nxt  = '0;
        page_open_nxt   = 1'b0;
      end else begin
        line_left_nxt   = nl_left;
        line_right_nxt  = nl_right;
        line_top_nxt    = nl_top;
        line_bottom_nxt = nl_bottom;
        line_start_nxt  = nl_start;
        char_pos_nxt    = nl_pos;
        word_open_nxt   = !in_is_space;
        word_start_nxt  = nw_start;
        prev_right_nxt  = br;
        page_open_nxt   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_left_r   <= '0;
      line_right_r  <= '0;
      line_top_r    <= '0;
      line_bottom_r <= '0;
      line_start_r  <= '0;
      char_pos_r    <= '0;
      word_open_r   <= 1'b0;
      word_start_r  <= '0;
      prev_right_r  <= '0;
      page_open_r   <= 1'b0;
    end else begin
      line_left_r   <= line_left_nxt;
      line_right_r  <= line_right_nxt;
      line_top_r    <= line_top_nxt;
      line_bottom_r <= line_bottom_nxt;
      line_start_r  <= line_start_nxt;
      char_pos_r    <= char_pos_nxt;
      word_open_r   <= word_open_nxt;
      word_start_r  <= word_start_nxt;
      prev_right_r  <= prev_right_nxt;
      page_open_r   <= page_open_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/gbw_queue.sv @@
// Small bundle FIFO between the front end and the record emitter.
`default_nettype none

module gbw_queue
  import gbw_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push_valid,
  output logic    push_ready,
  input  bundle_t push_data,
  output logic    head_valid,
  output bundle_t head_data,
  input  logic    pop
);

  bundle_t                   entry_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                      do_push;

  assign push_ready = (cnt_r != QUEUE_CNT_BITS'(QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_data  = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QUEUE_PTR_BITS'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QUEUE_PTR_BITS'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !pop) begin
      cnt_nxt = cnt_r + QUEUE_CNT_BITS'(1);
    end else if (!do_push && pop) begin
      cnt_nxt = cnt_r - QUEUE_CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/gbw_back.sv @@
// Back end: sends bundle records through an output register, one per cycle unless stalled.
`default_nettype none

module gbw_back
  import gbw_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    head_valid,
  input  bundle_t head_data,
  output logic    pop,
  output logic    out_valid,
  input  logic    out_ready,
  output logic    out_record_kind,
  output f16_t    out_rec_left,
  output f16_t    out_rec_right,
  output f16_t    out_rec_top,
  output f16_t    out_rec_bottom,
  output f16_t    out_first_char,
  output f16_t    out_char_count,
  output logic    out_end_of_run
);

  rec_mask_t done_r, done_nxt;
  rec_mask_t rem, sel, after;
  logic      load, last_rec;
  logic      out_valid_r, out_valid_nxt;
  rec_kind_t kind_r, kind_nxt;
  f16_t      left_r, right_r, top_r, bottom_r, first_r, count_r;
  f16_t      left_nxt, right_nxt, top_nxt, bottom_nxt, first_nxt, count_nxt;
  logic      eor_r;

  always_comb begin
    rem        = head_data.has & ~done_r;
    sel        = '0;
    if (rem.line0) begin
      sel.line0 = 1'b1;
    end else if (rem.word) begin
      sel.word = 1'b1;
    end else begin
      sel.line1 = 1'b1;
    end
    after    = rem & ~sel;
    last_rec = (after == '0);
    load     = head_valid && (!out_valid_r || out_ready);
    pop      = load && last_rec;
  end

  always_comb begin
    kind_nxt   = REC_LINE;
    left_nxt   = head_data.ln_left;
    right_nxt  = head_data.ln_right;
    top_nxt    = head_data.ln_top;
    bottom_nxt = head_data.ln_bottom;
    first_nxt  = head_data.ln_first;
    count_nxt  = head_data.ln_count;
    if (sel.line0) begin
      left_nxt   = head_data.l0_left;
      right_nxt  = head_data.l0_right;
      top_nxt    = head_data.l0_top;
      bottom_nxt = head_data.l0_bottom;
      first_nxt  = head_data.l0_first;
      count_nxt  = head_data.l0_count;
    end else if (sel.word) begin
      kind_nxt  = REC_WORD;
      left_nxt  = head_data.w_left;
      right_nxt = head_data.w_right;
      first_nxt = '0;
      count_nxt = '0;
    end
  end

  always_comb begin
    done_nxt      = done_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      done_nxt      = last_rec ? rec_mask_t'('0) : (done_r | sel);
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r   <= kind_nxt;
      left_r   <= left_nxt;
      right_r  <= right_nxt;
      top_r    <= top_nxt;
      bottom_r <= bottom_nxt;
      first_r  <= first_nxt;
      count_r  <= count_nxt;
      eor_r    <= last_rec;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_record_kind = kind_r;
  assign out_rec_left    = left_r;
  assign out_rec_right   = right_r;
  assign out_rec_top     = top_r;
  assign out_rec_bottom  = bottom_r;
  assign out_first_char  = first_r;
  assign out_char_count  = count_r;
  assign out_end_of_run  = eor_r;

  // a queued bundle always has a record left to send
  a_head_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid |-> (rem != '0))
    else $error("queued bundle with no records left");

  // retiring a bundle leaves its final record, flagged end of run, at the output
  a_pop_marks_end: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (out_valid_r && eor_r))
    else $error("bundle retired without end-of-run record");

  // progress mask is clear whenever no bundle is waiting
  a_done_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !head_valid |-> (done_r == '0))
    else $error("stale progress mask with empty queue");

endmodule

`default_nettype wire

@@ rtl/core/glyph_box_line_word_grouper_core.sv @@
// Top level of the glyph box line and word grouper: front end, bundle queue, record emitter.
//
//  channel | direction | handshake           | payload
//  in_     | input     | in_valid/in_ready   | box edges, space flag, page first/last marks
//  out_    | output    | out_valid/out_ready | one line or word record
//
// One box is accepted per cycle while the four-entry bundle queue has room.
// Each box yields zero to three records; the emitter sends one record per cycle
// unless the output is stalled by out_ready.
// The output register lets the next record load in the cycle the current one is taken.
// Synchronous active-low reset clears line/word state, queue pointers and output valid.
`default_nettype none

module glyph_box_line_word_grouper_core
  import gbw_pkg::*;
#(
  parameter int COORD_BITS = 16,
  parameter int INDEX_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_box_left,
  input  logic signed [15:0] in_box_right,
  input  logic signed [15:0] in_box_top,
  input  logic signed [15:0] in_box_bottom,
  input  logic               in_is_space,
  input  logic               in_first_of_page,
  input  logic               in_last_of_page,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_record_kind,
  output logic signed [15:0] out_rec_left,
  output logic signed [15:0] out_rec_right,
  output logic signed [15:0] out_rec_top,
  output logic signed [15:0] out_rec_bottom,
  output logic        [15:0] out_first_char,
  output logic        [15:0] out_char_count,
  output logic               out_end_of_run
);

  logic    push_valid, push_ready, head_valid, pop;
  bundle_t push_data, head_data;

  gbw_front #(
    .COORD_BITS(COORD_BITS),
    .INDEX_BITS(INDEX_BITS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_box_left      (in_box_left),
    .in_box_right     (in_box_right),
    .in_box_top       (in_box_top),
    .in_box_bottom    (in_box_bottom),
    .in_is_space      (in_is_space),
    .in_first_of_page (in_first_of_page),
    .in_last_of_page  (in_last_of_page),
    .push_valid       (push_valid),
    .push_ready       (push_ready),
    .push_data        (push_data)
  );

  gbw_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop)
  );

  gbw_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (head_valid),
    .head_data       (head_data),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_record_kind (out_record_kind),
    .out_rec_left    (out_rec_left),
    .out_rec_right   (out_rec_right),
    .out_rec_top     (out_rec_top),
    .out_rec_bottom  (out_rec_bottom),
    .out_first_char  (out_first_char),
    .out_char_count  (out_char_count),
    .out_end_of_run  (out_end_of_run)
  );

endmodule

`default_nettype wire

@@ bench/tb_glyph_box_line_word_grouper_core.sv @@
// Self-checking testbench for the glyph box line and word grouper core.
`timescale 1ns / 100ps

module tb_glyph_box_line_word_grouper_core;
  import gbw_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int N_SCRIPT    = 20;
  localparam int RAND_BOXES  = 380;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    f16_t left;
    f16_t right;
    f16_t top;
    f16_t bottom;
    logic sp;
    logic first_mark;
    logic last_mark;
  } box_t;

  typedef struct packed {
    rec_kind_t kind;
    f16_t      left;
    f16_t      right;
    f16_t      top;
    f16_t      bottom;
    f16_t      first_idx;
    f16_t      n_chars;
    logic      eor;
  } rec_t;

  // n_typed < 0: expectation comes from the grouping model
  typedef struct {
    box_t bx;
    int   n_typed;
  } script_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [15:0] in_box_left = '0;
  logic signed [15:0] in_box_right = '0;
  logic signed [15:0] in_box_top = '0;
  logic signed [15:0] in_box_bottom = '0;
  logic               in_is_space = 1'b0;
  logic               in_first_of_page = 1'b0;
  logic               in_last_of_page = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_record_kind;
  logic signed [15:0] out_rec_left;
  logic signed [15:0] out_rec_right;
  logic signed [15:0] out_rec_top;
  logic signed [15:0] out_rec_bottom;
  logic        [15:0] out_first_char;
  logic        [15:0] out_char_count;
  logic               out_end_of_run;

  glyph_box_line_word_grouper_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_box_left      (in_box_left),
    .in_box_right     (in_box_right),
    .in_box_top       (in_box_top),
    .in_box_bottom    (in_box_bottom),
    .in_is_space      (in_is_space),
    .in_first_of_page (in_first_of_page),
    .in_last_of_page  (in_last_of_page),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_record_kind  (out_record_kind),
    .out_rec_left     (out_rec_left),
    .out_rec_right    (out_rec_right),
    .out_rec_top      (out_rec_top),
    .out_rec_bottom   (out_rec_bottom),
    .out_first_char   (out_first_char),
    .out_char_count   (out_char_count),
    .out_end_of_run   (out_end_of_run)
  );

  always #5 clk = ~clk;

  // grouping state
  logic signed [15:0] ln_l = '0, ln_r = '0, ln_t = '0, ln_b = '0;
  logic        [15:0] ln_start = '0, chr_pos = '0;
  logic               wrd_open = 1'b0;
  logic signed [15:0] wrd_x = '0, prev_r = '0;
  logic               pg_open = 1'b0;

  rec_t        expected_records[$];
  rec_t        typed_recs[$];
  script_row_t box_script[N_SCRIPT];

  int errors = 0;
  int boxes_sent = 0;
  int lines_seen = 0;
  int words_seen = 0;
  int cycle_count = 0;
  int burst_left = 0;
  int max_gap = 6;

  // receiver stall control
  logic hold_req = 1'b0;
  logic hold_taken = 1'b0;
  int   hold_left = 0;
  int   rx_mode = 0;
  int   rx_mode_left = 0;

  function automatic void append_rec(ref rec_t q[$], input rec_t rc);
    q = {q, rc};
  endfunction

  function automatic rec_t line_record();
    int span;
    span = (chr_pos >= ln_start) ? int'(chr_pos) - int'(ln_start) + 1 : 1;
    if (span > 65535) span = 65535;
    return '{REC_LINE, ln_l, ln_r, ln_t, ln_b, ln_start, span[15:0], 1'b0};
  endfunction

  function automatic rec_t word_record(input logic signed [15:0] right_edge);
    return '{REC_WORD, wrd_x, right_edge, ln_t, ln_b, 16'd0, 16'd0, 1'b0};
  endfunction

  // Work out the records one box causes and advance the line/word state.
  function automatic void group_box(input box_t bx, ref rec_t batch[$]);
    logic signed [15:0] l, r, t, b;
    logic        [15:0] idx;
    l = bx.left;
    r = bx.right;
    t = bx.top;
    b = bx.bottom;
    batch.delete();
    if (bx.first_mark || !pg_open) begin
      ln_l = l; ln_r = r; ln_t = t; ln_b = b;
      ln_start = '0;
      chr_pos  = '0;
      wrd_open = !bx.sp;
      wrd_x    = l;
      pg_open  = 1'b1;
    end else begin
      idx = (chr_pos != 16'hFFFF) ? chr_pos + 16'd1 : chr_pos;
      if (t <= ln_b && b >= ln_t) begin
        if (l < ln_l) ln_l = l;
        if (r > ln_r) ln_r = r;
        if (t < ln_t) ln_t = t;
        if (b > ln_b) ln_b = b;
      end else begin
        append_rec(batch, line_record());
        ln_l = l; ln_r = r; ln_t = t; ln_b = b;
        ln_start = idx;
      end
      chr_pos = idx;
      if (!bx.sp && !wrd_open) begin
        wrd_open = 1'b1;
        wrd_x    = l;
      end
      // a space closes the word at the previous box's right edge
      if (bx.sp && wrd_open) begin
        append_rec(batch, word_record(prev_r));
        wrd_open = 1'b0;
      end
    end
    prev_r = r;
    if (bx.last_mark) begin
      if (wrd_open) append_rec(batch, word_record(r));
      append_rec(batch, line_record());
      ln_l = '0; ln_r = '0; ln_t = '0; ln_b = '0;
      ln_start = '0; chr_pos = '0;
      wrd_open = 1'b0; wrd_x = '0; prev_r = '0;
      pg_open = 1'b0;
    end
    if (batch.size() > 0) batch[batch.size() - 1].eor = 1'b1;
  endfunction

  function automatic f16_t to_q(input int v);
    if (v > 32767) return 16'h7FFF;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  function automatic string fmt_rec(input rec_t rc);
    return $sformatf("kind=%0d l=%0d r=%0d t=%0d b=%0d first=%0d cnt=%0d eor=%0d",
                     rc.kind, $signed(rc.left), $signed(rc.right), $signed(rc.top),
                     $signed(rc.bottom), rc.first_idx, rc.n_chars, rc.eor);
  endfunction

  function automatic void note_error(input string msg);
    errors++;
    if (errors <= 10) $display("[%0t] ERROR: %s", $realtime, msg);
  endfunction

  // Offer one box request in bursts with random gaps, then book its records.
  task automatic send_box(input box_t bx, input int n_typed);
    rec_t batch[$];
    int   gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, max_gap);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid         <= 1'b1;
    in_box_left      <= bx.left;
    in_box_right     <= bx.right;
    in_box_top       <= bx.top;
    in_box_bottom    <= bx.bottom;
    in_is_space      <= bx.sp;
    in_first_of_page <= bx.first_mark;
    in_last_of_page  <= bx.last_mark;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    group_box(bx, batch);
    if (n_typed < 0) begin
      foreach (batch[i]) append_rec(expected_records, batch[i]);
    end else begin
      for (int i = 0; i < n_typed; i++) append_rec(expected_records, typed_recs.pop_front());
    end
    boxes_sent++;
  endtask

  // receiver: shifting ready patterns plus one long hold-off
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      out_ready  <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      <= $urandom_range(0, 2);
        rx_mode_left <= $urandom_range(20, 80);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= ($urandom_range(0, 9) < 7);
        default: out_ready <= ($urandom_range(0, 9) < 3);
      endcase
    end
  end

  // record checker
  always @(posedge clk) begin
    rec_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = '{rec_kind_t'(out_record_kind), out_rec_left, out_rec_right, out_rec_top,
              out_rec_bottom, out_first_char, out_char_count, out_end_of_run};
      if (got.kind == REC_WORD) words_seen++;
      else lines_seen++;
      if (expected_records.size() == 0) begin
        note_error($sformatf("unexpected record: %s", fmt_rec(got)));
      end else begin
        want = expected_records.pop_front();
        if (got.kind !== want.kind || got.left !== want.left || got.right !== want.right ||
            got.top !== want.top || got.bottom !== want.bottom ||
            got.first_idx !== want.first_idx || got.n_chars !== want.n_chars ||
            got.eor !== want.eor)
          note_error($sformatf("record mismatch\n  expected %s\n  actual   %s",
                               fmt_rec(want), fmt_rec(got)));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d records outstanding",
               cycle_count, expected_records.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    box_t bx;
    int   rand_sent;
    int   n, x, y, h, w;
    rand_sent = 0;

    // left, right, top, bottom, space, first, last
    box_script = '{
      // one-box pages at the coordinate extremes
      '{'{-32768, 32767, -32768, 32767, 1'b0, 1'b1, 1'b1}, 2},
      '{'{32767, -32768, 32767, -32768, 1'b1, 1'b1, 1'b1}, 1},
      // page without a first mark, merge, word closed by space
      '{'{16, 32, 0, 160, 1'b0, 1'b0, 1'b0}, -1},
      '{'{40, 60, 8, 170, 1'b0, 1'b0, 1'b0}, -1},
      '{'{64, 70, 0, 160, 1'b1, 1'b0, 1'b0}, -1},
      '{'{72, 80, 0, 160, 1'b1, 1'b0, 1'b0}, -1},
      '{'{16, 30, 200, 360, 1'b0, 1'b0, 1'b0}, -1},
      // new line and word close together: word takes the new line's geometry
      '{'{16, 30, 400, 560, 1'b1, 1'b0, 1'b0}, -1},
      // repeated first mark drops the open line and word
      '{'{100, 120, -50, 50, 1'b0, 1'b1, 1'b0}, 0},
      '{'{130, 150, -60, 40, 1'b0, 1'b0, 1'b0}, -1},
      // inverted box merged edge by edge
      '{'{200, 160, 30, -40, 1'b0, 1'b0, 1'b0}, -1},
      // last mark on a new line with a space: line, word, line
      '{'{300, 320, 1000, 1100, 1'b1, 1'b0, 1'b1}, -1},
      '{'{0, 10, 0, 10, 1'b1, 1'b1, 1'b0}, -1},
      '{'{12, 20, 2, 12, 1'b0, 1'b0, 1'b0}, -1},
      '{'{22, 30, 1, 11, 1'b0, 1'b0, 1'b1}, -1},
      '{'{-100, -50, -20, 20, 1'b0, 1'b1, 1'b0}, -1},
      '{'{-40, -8, 500, 600, 1'b0, 1'b0, 1'b1}, -1},
      // touching edges count as overlap
      '{'{0, 16, 0, 100, 1'b0, 1'b1, 1'b0}, -1},
      '{'{20, 36, 100, 200, 1'b0, 1'b0, 1'b0}, -1},
      '{'{40, 56, 201, 300, 1'b1, 1'b0, 1'b1}, -1}
    };
    typed_recs = '{
      '{REC_WORD, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'd0, 16'd0, 1'b0},
      '{REC_LINE, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'd0, 16'd1, 1'b1},
      '{REC_LINE, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'd0, 16'd1, 1'b1}
    };

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_SCRIPT; i++) send_box(box_script[i].bx, box_script[i].n_typed);

    // random pages with well-formed structure, mixed with noise
    max_gap = 6;
    while (rand_sent < RAND_BOXES) begin
      if ($urandom_range(0, 99) < 85) begin
        n = $urandom_range(2, 25);
        y = $urandom_range(0, 50000) - 25000;
        h = $urandom_range(64, 320);
        x = $urandom_range(0, 20000) - 32000;
        for (int i = 0; i < n; i++) begin
          if (i > 0 && $urandom_range(0, 5) == 0) begin
            y = y + h + h / 4 + $urandom_range(1, 120);
            if (y > 30000) y = -31000;
            x = $urandom_range(0, 4000) - 32000;
          end
          w = $urandom_range(16, 240);
          bx.left       = to_q(x);
          bx.right      = to_q(x + w);
          bx.top        = to_q(y - $urandom_range(0, h / 4));
          bx.bottom     = to_q(y + h - $urandom_range(0, h / 4));
          bx.sp         = ($urandom_range(0, 3) == 0);
          bx.first_mark = (i == 0) ? ($urandom_range(0, 19) != 0) : ($urandom_range(0, 49) == 0);
          bx.last_mark  = (i == n - 1) ? ($urandom_range(0, 19) != 0) : 1'b0;
          send_box(bx, -1);
          x = x + w + $urandom_range(0, 40);
          if (x > 32000) x = -32000;
          rand_sent++;
          if (rand_sent == 100) hold_req <= 1'b1;
        end
      end else begin
        n = $urandom_range(1, 5);
        for (int i = 0; i < n; i++) begin
          bx.left       = 16'($urandom);
          bx.right      = 16'($urandom);
          bx.top        = 16'($urandom);
          bx.bottom     = 16'($urandom);
          bx.sp         = 1'($urandom_range(0, 1));
          bx.first_mark = 1'($urandom_range(0, 1));
          bx.last_mark  = 1'($urandom_range(0, 1));
          send_box(bx, -1);
          rand_sent++;
          if (rand_sent == 100) hold_req <= 1'b1;
        end
      end
    end
    in_valid <= 1'b0;

    while (expected_records.size() != 0) @(posedge clk);
    repeat (32) @(posedge clk);

    $display("Sent %0d boxes: %0d directed cases, %0d random across pages and noise",
             boxes_sent, N_SCRIPT, rand_sent);
    $display("Checked %0d line and %0d word records, %0d mismatches",
             lines_seen, words_seen, errors);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/gbw_pkg.sv
rtl/core/gbw_front.sv
rtl/core/gbw_queue.sv
rtl/core/gbw_back.sv
rtl/core/glyph_box_line_word_grouper_core.sv
bench/tb_glyph_box_line_word_grouper_core.sv
